### rtl/core/tea_block_cipher_round_trace_assert.svh
// Assertion macros shared by the checker of the TEA round trace block.
// Depends on nothing; included by the checker file only.
`ifndef TEA_BLOCK_CIPHER_ROUND_TRACE_ASSERT_SVH
`define TEA_BLOCK_CIPHER_ROUND_TRACE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define TEA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define TEA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/tea_rt_pkg.sv
// Package for the TEA round trace block: cipher constants, field widths
// and configuration register indexes. Depends on nothing.
package tea_rt_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned ROUND_W     = 6;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned MAX_ROUNDS  = 32;

    localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9e37_79b9;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_A       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_B       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_C       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_D       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROUND_COUNT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACE_EN    = 3'd5;

    localparam logic ACT_ENCRYPT = 1'b0;
    localparam logic ACT_DECRYPT = 1'b1;

    localparam logic [ROUND_W-1:0] ROUND_COUNT_RESET = 6'd32;

    typedef logic [WORD_W-1:0] t_word;

    // TEA mixing function of one half-round.
    function automatic t_word tea_mix(t_word v, t_word sum, t_word ka, t_word kb);
        return ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb);
    endfunction

endpackage

### rtl/core/tea_block_cipher_round_trace.sv
// Top level of the TEA block cipher with an optional per-round trace.
// Depends on tea_rt_pkg.
//
// Usage:
// The input channel takes one request per block: an action (0 encrypt,
// 1 decrypt) and the two 32-bit halves. The output channel returns block
// states with the number of rounds completed and a last flag. A separate
// configuration channel writes the four key words, the round count and the
// trace enable; it is always ready and must only be used while idle.
// One shared mixing unit does one half-round per cycle while the sequencer
// is not holding for the output register; a full round is two half-rounds.
// An untraced request gives its single result after R rounds, R being the
// effective round count (zero counts as one, anything above MAX_ROUNDS as
// MAX_ROUNDS). A traced encrypt shows the plaintext first and then the state
// after each round. A new request is accepted only once the block is idle
// again; the block is busy while it iterates. A result waits in the output
// register; if the receiver stalls while a further state is due, the
// sequencer holds until the register frees. The final result may still wait
// when the next request is taken. Reset clears the sequencer, the output
// valid and the configuration registers (keys zero, 32 rounds, trace off).
module tea_block_cipher_round_trace #(
    parameter int unsigned MAX_ROUNDS = tea_rt_pkg::MAX_ROUNDS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Input request channel.
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_action,
    input  logic [tea_rt_pkg::WORD_W-1:0]      i_half_low,
    input  logic [tea_rt_pkg::WORD_W-1:0]      i_half_high,
    // Result channel.
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [tea_rt_pkg::WORD_W-1:0]      o_out_low,
    output logic [tea_rt_pkg::WORD_W-1:0]      o_out_high,
    output logic [tea_rt_pkg::ROUND_W-1:0]     o_round_index,
    output logic                               o_last,
    // Configuration write channel.
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tea_rt_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tea_rt_pkg::WORD_W-1:0]      i_cfg_data
);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_PLAIN  = 2'd1;
    localparam logic [1:0] ST_HALF_A = 2'd2;
    localparam logic [1:0] ST_HALF_B = 2'd3;

    localparam int unsigned RW = tea_rt_pkg::ROUND_W;

    // Configuration registers.
    tea_rt_pkg::t_word r_key_a, r_key_b, r_key_c, r_key_d;
    logic [RW-1:0]     r_round_count;
    logic              r_trace_en;

    // Sequencer and working state.
    logic [1:0]        r_state, n_state;
    tea_rt_pkg::t_word r_v0, n_v0, r_v1, n_v1, r_sum, n_sum;
    logic [RW-1:0]     r_cnt, n_cnt, r_rounds, n_rounds;
    logic              r_dec, n_dec, r_trace, n_trace;

    // Output register.
    logic              r_out_valid, n_out_valid;
    tea_rt_pkg::t_word r_out_low, n_out_low, r_out_high, n_out_high;
    logic [RW-1:0]     r_out_idx, n_out_idx;
    logic              r_out_last, n_out_last;

    logic              in_acc;
    logic              out_free;
    logic [RW-1:0]     eff_rounds;
    logic              upd_low;
    tea_rt_pkg::t_word mix_src, mix_ka, mix_kb, mix_val, mix_tgt, mix_res;
    logic [RW-1:0]     cnt_inc;
    logic              emit_now;
    logic              round_done;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    // Zero rounds means one round; the count saturates at MAX_ROUNDS.
    always_comb begin
        priority if (r_round_count == '0) begin
            eff_rounds = RW'(1);
        end else if ({1'b0, r_round_count} > (RW+1)'(MAX_ROUNDS)) begin
            eff_rounds = RW'(MAX_ROUNDS);
        end else begin
            eff_rounds = r_round_count;
        end
    end

    // The shared unit updates v0 (from v1, keys a/b) on the first half of an
    // encrypt round and the second half of a decrypt round; otherwise v1.
    assign upd_low = (r_state == ST_HALF_A) ? !r_dec : r_dec;
    assign mix_src = upd_low ? r_v1 : r_v0;
    assign mix_ka  = upd_low ? r_key_a : r_key_c;
    assign mix_kb  = upd_low ? r_key_b : r_key_d;
    assign mix_tgt = upd_low ? r_v0 : r_v1;
    assign mix_val = tea_rt_pkg::tea_mix(mix_src, r_sum, mix_ka, mix_kb);
    assign mix_res = r_dec ? (mix_tgt - mix_val) : (mix_tgt + mix_val);

    assign cnt_inc    = r_cnt + RW'(1);
    assign round_done = (cnt_inc == r_rounds);
    assign emit_now   = r_trace || round_done;

    always_comb begin
        n_state     = r_state;
        n_v0        = r_v0;
        n_v1        = r_v1;
        n_sum       = r_sum;
        n_cnt       = r_cnt;
        n_rounds    = r_rounds;
        n_dec       = r_dec;
        n_trace     = r_trace;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_low   = r_out_low;
        n_out_high  = r_out_high;
        n_out_idx   = r_out_idx;
        n_out_last  = r_out_last;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_v0     = i_half_low;
                    n_v1     = i_half_high;
                    n_cnt    = '0;
                    n_rounds = eff_rounds;
                    n_dec    = (i_action == tea_rt_pkg::ACT_DECRYPT);
                    n_trace  = r_trace_en && (i_action == tea_rt_pkg::ACT_ENCRYPT);
                    // Decrypt starts from delta times the round count.
                    n_sum    = (i_action == tea_rt_pkg::ACT_DECRYPT) ?
                               tea_rt_pkg::TEA_DELTA * tea_rt_pkg::WORD_W'(eff_rounds) :
                               tea_rt_pkg::TEA_DELTA;
                    n_state  = n_trace ? ST_PLAIN : ST_HALF_A;
                end
            end
            ST_PLAIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_low   = r_v0;
                    n_out_high  = r_v1;
                    n_out_idx   = '0;
                    n_out_last  = 1'b0;
                    n_state     = ST_HALF_A;
                end
            end
            ST_HALF_A: begin
                if (upd_low) begin
                    n_v0 = mix_res;
                end else begin
                    n_v1 = mix_res;
                end
                n_state = ST_HALF_B;
            end
            ST_HALF_B: begin
                // Hold the round when a result is due and the output is full.
                if (!emit_now || out_free) begin
                    if (upd_low) begin
                        n_v0 = mix_res;
                    end else begin
                        n_v1 = mix_res;
                    end
                    n_cnt = cnt_inc;
                    n_sum = r_dec ? (r_sum - tea_rt_pkg::TEA_DELTA) :
                                    (r_sum + tea_rt_pkg::TEA_DELTA);
                    if (emit_now) begin
                        n_out_valid = 1'b1;
                        n_out_low   = upd_low ? mix_res : r_v0;
                        n_out_high  = upd_low ? r_v1 : mix_res;
                        n_out_idx   = cnt_inc;
                        n_out_last  = round_done;
                    end
                    n_state = round_done ? ST_IDLE : ST_HALF_A;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and output payload.
    always_ff @(posedge i_clk) begin
        r_v0       <= n_v0;
        r_v1       <= n_v1;
        r_sum      <= n_sum;
        r_cnt      <= n_cnt;
        r_rounds   <= n_rounds;
        r_dec      <= n_dec;
        r_trace    <= n_trace;
        r_out_low  <= n_out_low;
        r_out_high <= n_out_high;
        r_out_idx  <= n_out_idx;
        r_out_last <= n_out_last;
    end

    // Configuration registers; indexes past the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_a       <= '0;
            r_key_b       <= '0;
            r_key_c       <= '0;
            r_key_d       <= '0;
            r_round_count <= tea_rt_pkg::ROUND_COUNT_RESET;
            r_trace_en    <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                tea_rt_pkg::CFG_KEY_A:       r_key_a       <= i_cfg_data;
                tea_rt_pkg::CFG_KEY_B:       r_key_b       <= i_cfg_data;
                tea_rt_pkg::CFG_KEY_C:       r_key_c       <= i_cfg_data;
                tea_rt_pkg::CFG_KEY_D:       r_key_d       <= i_cfg_data;
                tea_rt_pkg::CFG_ROUND_COUNT: r_round_count <= i_cfg_data[RW-1:0];
                tea_rt_pkg::CFG_TRACE_EN:    r_trace_en    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_low     = r_out_low;
    assign o_out_high    = r_out_high;
    assign o_round_index = r_out_idx;
    assign o_last        = r_out_last;

endmodule

### rtl/core/tea_rt_checker.sv
// Port-level checker for the TEA round trace block, bound to the top level.
// Depends on tea_rt_pkg and tea_block_cipher_round_trace_assert.svh.
`include "tea_block_cipher_round_trace_assert.svh"

module tea_rt_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_ready,
    input logic                             o_out_valid,
    input logic                             i_out_ready,
    input logic [tea_rt_pkg::WORD_W-1:0]    o_out_low,
    input logic [tea_rt_pkg::WORD_W-1:0]    o_out_high,
    input logic [tea_rt_pkg::ROUND_W-1:0]   o_round_index,
    input logic                             o_last
);

    // A stalled result keeps its valid and payload.
    `TEA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_low) && $stable(o_out_high) && $stable(o_round_index) && $stable(o_last), "stalled result changed")

    // Every request runs at least one round, so the block is busy next cycle.
    `TEA_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "block ready right after a request")

    // The final result always follows at least one round.
    `TEA_ASSERT_NOW(a_last_has_rounds, i_clk, i_rst_n, o_out_valid && o_last, o_round_index != '0, "final result with zero rounds")

    // The plaintext trace entry is never the final result.
    `TEA_ASSERT_NOW(a_plain_not_last, i_clk, i_rst_n, o_out_valid && (o_round_index == '0), !o_last, "plaintext marked final")

endmodule

bind tea_block_cipher_round_trace tea_rt_checker u_tea_rt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_out_low     (o_out_low),
    .o_out_high    (o_out_high),
    .o_round_index (o_round_index),
    .o_last        (o_last)
);
